[rtl/abmb_pkg.sv]
// Shared types, constants and helpers for the axis bucket mean binner.
// Used by abmb_div and axis_bucket_mean_binner_core; depends on nothing else.
package abmb_pkg;

  localparam int BUCKET_W    = 7;
  localparam int MAX_BUCKETS = 1 << BUCKET_W;
  localparam int NB_W        = 8;

  localparam int DIV_STEPS   = 64;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] REG_NUM_BUCKETS   = 2'd0;
  localparam logic [1:0] REG_ORIGIN        = 2'd1;
  localparam logic [1:0] REG_INVERSE_WIDTH = 2'd2;
  localparam logic [1:0] REG_BUCKET_WIDTH  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_INDEX,
    ST_READ,
    ST_MODIFY,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Bucket count actually in use: zero acts as one, anything above the
  // store depth acts as the store depth.
  function automatic logic [NB_W-1:0] eff_buckets(input logic [NB_W-1:0] nb);
    logic [NB_W-1:0] n;
    n = nb;
    if (nb == '0) begin
      n = NB_W'(1);
    end else if (nb > NB_W'(MAX_BUCKETS)) begin
      n = NB_W'(MAX_BUCKETS);
    end
    return n;
  endfunction

endpackage

[rtl/abmb_div.sv]
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// Depends on abmb_pkg for the step count and the status struct.
module abmb_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         dividend,
  input  logic [31:0]         divisor,
  output abmb_pkg::div_stat_t stat,
  output logic [31:0]         quotient
);

  logic [31:0]                    rem;
  logic [63:0]                    dq;
  logic [31:0]                    dvs;
  logic [abmb_pkg::DIV_CNT_W-1:0] step;
  logic                           busy;
  logic                           done;
  logic [32:0]                    shifted;
  logic                           fits;

  // The dividend register shifts out at the top while quotient bits enter
  // at the bottom, so it holds the full quotient after the last step.
  assign shifted = {rem, dq[63]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == abmb_pkg::DIV_CNT_W'(abmb_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? 32'(shifted - {1'b0, dvs}) : shifted[31:0];
      dq  <= {dq[62:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dq[31:0];

endmodule

[rtl/axis_bucket_mean_binner_core.sv]
// Sequence: a sample beat steps through ST_DIFF, ST_MUL, ST_INDEX, ST_READ, ST_MODIFY and
// ST_DONE; a read beat starts at ST_READ and adds ST_DIV (64-step divider) for a filled bucket.
// Beats are handled one at a time; a finished beat waits in ST_DONE until the output register
// is free, and the next beat is accepted in the cycle after the result moves into it.
// Reset (synchronous, active high) restores the state, configuration and control registers and
// clears the per-bucket valid flags, so both stores read as zero at once; there is no sweep.
module axis_bucket_mean_binner_core (
  input  logic               clk,
  input  logic               rst,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [31:0] position,
  input  logic signed [31:0] sample_value,
  input  logic [6:0]         read_bucket,
  // Output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         bucket,
  output logic signed [31:0] mean,
  output logic [31:0]        sample_count,
  output logic [38:0]        centre
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; reads are
  // served straight from the registers.
  // ---------------------------------------------------------------------------
  logic [abmb_pkg::NB_W-1:0] num_buckets;
  logic signed [31:0]        origin;
  logic [31:0]               inverse_width;
  logic [31:0]               bucket_width;
  logic [abmb_pkg::NB_W-1:0] n_eff;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buckets   <= abmb_pkg::NB_W'(100);
      origin        <= '0;
      inverse_width <= 32'h0001_0000;
      bucket_width  <= 32'h0001_0000;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        abmb_pkg::REG_NUM_BUCKETS:   num_buckets   <= pwdata[abmb_pkg::NB_W-1:0];
        abmb_pkg::REG_ORIGIN:        origin        <= pwdata;
        abmb_pkg::REG_INVERSE_WIDTH: inverse_width <= pwdata;
        abmb_pkg::REG_BUCKET_WIDTH:  bucket_width  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      abmb_pkg::REG_NUM_BUCKETS:   prdata = {24'b0, num_buckets};
      abmb_pkg::REG_ORIGIN:        prdata = origin;
      abmb_pkg::REG_INVERSE_WIDTH: prdata = inverse_width;
      abmb_pkg::REG_BUCKET_WIDTH:  prdata = bucket_width;
      default:                     prdata = '0;
    endcase
  end

  assign n_eff = abmb_pkg::eff_buckets(num_buckets);

  // ---------------------------------------------------------------------------
  // Sequencer state and per-beat working registers.
  // ---------------------------------------------------------------------------
  abmb_pkg::state_t state, state_next;

  logic                             op_q;
  logic signed [31:0]               position_q;
  logic signed [31:0]               value_q;
  logic [abmb_pkg::BUCKET_W-1:0]    idx;
  logic [abmb_pkg::BUCKET_W-1:0]    idx_calc;
  logic signed [32:0]               diff;
  logic                             diff_pos;
  logic [63:0]                      prod;
  logic [38:0]                      centre_prod;
  logic                             in_range;
  logic                             neg;
  logic [31:0]                      res_count;
  logic [38:0]                      res_centre;
  logic [31:0]                      mean_q;

  // Bucket stores: one synchronous memory for the sums, one for the counts,
  // plus a valid flag per entry so that reset needs no sweep.
  logic [63:0]                      sum_mem [abmb_pkg::MAX_BUCKETS];
  logic [31:0]                      cnt_mem [abmb_pkg::MAX_BUCKETS];
  logic [abmb_pkg::MAX_BUCKETS-1:0] ent_valid;
  logic [63:0]                      sum_rd;
  logic [31:0]                      cnt_rd;
  logic                             ent_valid_rd;
  logic [63:0]                      sum_cur;
  logic [31:0]                      cnt_cur;
  logic                             mem_we;
  logic [63:0]                      sum_wr;
  logic [31:0]                      cnt_wr;

  logic                             div_start;
  abmb_pkg::div_stat_t              div_stat;
  logic [31:0]                      div_q;
  logic [63:0]                      mag;

  logic                             slot_free;
  logic                             out_load;

  assign slot_free = !out_valid || out_ready;

  // ---------------------------------------------------------------------------
  // Read-modify-write path. The stores are read in ST_READ and the registered data is used
  // in ST_MODIFY, where a sample beat writes the updated entry back and a read beat in range
  // writes it as zero. Only one beat is in flight, so a read never overlaps a pending write.
  // ---------------------------------------------------------------------------
  assign sum_cur = ent_valid_rd ? sum_rd : '0;
  assign cnt_cur = ent_valid_rd ? cnt_rd : '0;
  assign mag     = sum_cur[63] ? (64'd0 - sum_cur) : sum_cur;

  always_comb begin
    if (!diff_pos) begin
      idx_calc = '0;
    end else if (prod[63:32] >= {24'b0, n_eff}) begin
      idx_calc = abmb_pkg::BUCKET_W'(n_eff - 1'b1);
    end else begin
      idx_calc = prod[32 +: abmb_pkg::BUCKET_W];
    end
  end

  always_ff @(posedge clk) begin
    state <= rst ? abmb_pkg::ST_IDLE : state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    sum_wr     = '0;
    cnt_wr     = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      abmb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (op == abmb_pkg::OP_READ) ? abmb_pkg::ST_READ : abmb_pkg::ST_DIFF;
        end
      end
      abmb_pkg::ST_DIFF:  state_next = abmb_pkg::ST_MUL;
      abmb_pkg::ST_MUL:   state_next = abmb_pkg::ST_INDEX;
      abmb_pkg::ST_INDEX: state_next = abmb_pkg::ST_READ;
      abmb_pkg::ST_READ:  state_next = abmb_pkg::ST_MODIFY;
      abmb_pkg::ST_MODIFY: begin
        if (op_q == abmb_pkg::OP_SAMPLE) begin
          // A saturated bucket ignores further samples.
          if (cnt_cur != abmb_pkg::COUNT_MAX) begin
            mem_we = 1'b1;
            sum_wr = sum_cur + 64'(value_q);
            cnt_wr = cnt_cur + 1'b1;
          end
        end else if (in_range) begin
          mem_we    = 1'b1;
          div_start = cnt_cur != '0;
        end
        state_next = div_start ? abmb_pkg::ST_DIV : abmb_pkg::ST_DONE;
      end
      abmb_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = abmb_pkg::ST_DONE;
        end
      end
      abmb_pkg::ST_DONE: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = abmb_pkg::ST_IDLE;
        end
      end
      default: state_next = abmb_pkg::ST_IDLE;
    endcase
  end

  // Working registers, each loaded in the step that produces it.
  always_ff @(posedge clk) begin
    case (state)
      abmb_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_q       <= op;
          position_q <= position;
          value_q    <= sample_value;
          idx        <= read_bucket;
        end
      end
      abmb_pkg::ST_DIFF: begin
        diff <= 33'(position_q) - 33'(origin);
      end
      abmb_pkg::ST_MUL: begin
        // The offset is positive here only when it fits 32 unsigned bits.
        prod     <= 64'(diff[31:0]) * 64'(inverse_width);
        diff_pos <= !diff[32] && (diff != '0);
      end
      abmb_pkg::ST_INDEX: begin
        idx <= idx_calc;
      end
      abmb_pkg::ST_READ: begin
        centre_prod <= 39'(bucket_width) * 39'(idx);
        in_range    <= {1'b0, idx} < n_eff;
      end
      abmb_pkg::ST_MODIFY: begin
        neg    <= sum_cur[63];
        mean_q <= '0;
        if (op_q == abmb_pkg::OP_SAMPLE) begin
          res_count <= (cnt_cur != abmb_pkg::COUNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
        end else begin
          res_count <= in_range ? cnt_cur : '0;
        end
        res_centre <= in_range ? centre_prod + 39'(bucket_width[31:1]) : '0;
      end
      abmb_pkg::ST_DIV: begin
        if (div_stat.done) begin
          mean_q <= neg ? (32'd0 - div_q) : div_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[idx] <= sum_wr;
      cnt_mem[idx] <= cnt_wr;
    end
    sum_rd <= sum_mem[idx];
    cnt_rd <= cnt_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid    <= '0;
      ent_valid_rd <= 1'b0;
    end else begin
      ent_valid_rd <= ent_valid[idx];
      if (mem_we) begin
        ent_valid[idx] <= 1'b1;
      end
    end
  end

  // The magnitude of the sum is divided by the count; the sign is put back
  // on the truncated quotient, which always fits 32 bits.
  abmb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (cnt_cur),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------
  // Output register. It holds a finished beat while the sequencer goes back
  // to idle and takes the next input beat.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bucket       <= idx;
      mean         <= mean_q;
      sample_count <= res_count;
      centre       <= res_centre;
    end
  end

`ifndef SYNTHESIS
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ({1'b0, idx} < n_eff))
    else $error("store written outside the buckets in use");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == abmb_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

  a_sample_count: assert property (@(posedge clk) disable iff (rst)
    (state == abmb_pkg::ST_DONE && op_q == abmb_pkg::OP_SAMPLE) |-> (res_count != '0))
    else $error("sample beat finished with an empty bucket count");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != abmb_pkg::ST_IDLE))
    else $error("accepted beat did not start work");
`endif

endmodule
